/* hw/rtl/mtrq_pkg.sv */
package mtrq_pkg;

  // operation codes
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  // result status codes
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_RANGE = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;
  localparam logic [1:0] STAT_EMPTY = 2'd3;

  // configuration register indexes
  localparam logic CFG_TRACKS = 1'b0;
  localparam logic CFG_DEPTH  = 1'b1;

  // configuration reset values
  localparam logic [4:0] TRACKS_RESET = 5'd16;
  localparam logic [6:0] DEPTH_RESET  = 7'd64;

  // sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOKUP,
    S_FINISH
  } state_t;

endpackage

/* hw/rtl/multi_track_ring_queue_unit.sv */
// Flow: an accepted item's track descriptor is read, then the entry store is read or
// written and the descriptor written back, and the result goes to the output register.
// One item at a time: the next is accepted only after the last has left the finishing state.
// A stalled result holds the unit in its finishing state until the item is taken.
// Reset: configuration returns to 16 tracks and depth 64; per-track valid flags are
// cleared so all pointers and counts read as zero; entry store contents are left as is.
module multi_track_ring_queue_unit
  import mtrq_pkg::*;
#(
  parameter int TRACKS     = 16,
  parameter int DEPTH      = 64,
  parameter int DATA_WIDTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  // request channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        operation,
  input  logic [3:0]  track,
  input  logic [63:0] push_data,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [63:0] pop_data,
  // configuration channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [6:0]  cfg_data
);

  localparam int PW  = $clog2(DEPTH);
  localparam int CW  = $clog2(DEPTH + 1);
  localparam int LW  = (CW > 7) ? CW : 7;
  localparam int MIW = (TRACKS > 1) ? $clog2(TRACKS) : 1;
  localparam int SD  = TRACKS * DEPTH;
  localparam int AW  = (SD > 1) ? $clog2(SD) : 1;
  localparam int MW  = 2 * PW + CW;

  // next pointer value, wrapping at the live depth
  function automatic logic [PW-1:0] advance(input logic [PW-1:0] ptr,
                                            input logic [CW-1:0] lim);
    logic [CW-1:0] nxt;
    nxt = CW'(ptr) + CW'(1);
    if (nxt >= lim || nxt >= CW'(DEPTH)) begin
      return '0;
    end
    return PW'(nxt);
  endfunction

  state_t state, state_next;

  logic [4:0] tracks_in_use;
  logic [6:0] depth_in_use;

  // latched request
  logic                  op_q;
  logic [3:0]            trk_q;
  logic [DATA_WIDTH-1:0] data_q;
  logic                  hit_vld;

  // descriptor valid flags, one per track
  logic [TRACKS-1:0] meta_vld;

  // result held between lookup and finish
  logic [1:0] res_status;
  logic       res_pop;

  // descriptor memory
  logic           meta_we, meta_re;
  logic [MIW-1:0] meta_waddr, meta_raddr;
  logic [MW-1:0]  meta_wdata, meta_rdata;

  // entry store
  logic                  store_we, store_re;
  logic [AW-1:0]         store_waddr, store_raddr;
  logic [DATA_WIDTH-1:0] store_rdata;

  // lookup datapath
  logic [MW-1:0]  meta_q;
  logic [PW-1:0]  rp, wp, rp_new, wp_new;
  logic [CW-1:0]  cnt, cnt_new, live_depth;
  logic [LW-1:0]  dep_wide;
  logic [MIW-1:0] idx_q;
  logic [AW-1:0]  base;
  logic           in_range, push_ok, pop_ok;
  logic [1:0]     lk_status;
  logic           accept, finish;

  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;

  mtrq_ram #(.WIDTH(MW), .DEPTH(TRACKS)) u_meta_ram (
    .clk   (clk),
    .we    (meta_we),
    .waddr (meta_waddr),
    .wdata (meta_wdata),
    .re    (meta_re),
    .raddr (meta_raddr),
    .rdata (meta_rdata)
  );

  mtrq_ram #(.WIDTH(DATA_WIDTH), .DEPTH(SD)) u_store_ram (
    .clk   (clk),
    .we    (store_we),
    .waddr (store_waddr),
    .wdata (data_q),
    .re    (store_re),
    .raddr (store_raddr),
    .rdata (store_rdata)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      tracks_in_use <= TRACKS_RESET;
      depth_in_use  <= DEPTH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_TRACKS: tracks_in_use <= cfg_data[4:0];
        CFG_DEPTH:  depth_in_use  <= cfg_data;
        default:    ;
      endcase
    end
  end

  // live depth, saturated to the store depth
  always_comb begin
    dep_wide = LW'(depth_in_use);
    if (dep_wide > LW'(DEPTH)) begin
      dep_wide = LW'(DEPTH);
    end
    live_depth = CW'(dep_wide);
  end

  // lookup: decode descriptor and decide the access
  always_comb begin
    idx_q    = MIW'(trk_q);
    meta_q   = hit_vld ? meta_rdata : '0;
    rp       = meta_q[MW-1 -: PW];
    wp       = meta_q[CW +: PW];
    cnt      = meta_q[CW-1:0];
    in_range = (9'(trk_q) < 9'(tracks_in_use)) && (9'(trk_q) < 9'(TRACKS));
    push_ok  = in_range && (op_q == OP_PUSH) && (cnt < live_depth);
    pop_ok   = in_range && (op_q == OP_POP) && (cnt != '0);
    base     = AW'(idx_q) * AW'(DEPTH);
    rp_new   = pop_ok ? advance(rp, live_depth) : rp;
    wp_new   = push_ok ? advance(wp, live_depth) : wp;
    cnt_new  = push_ok ? cnt + CW'(1) : (pop_ok ? cnt - CW'(1) : cnt);
    priority if (!in_range) begin
      lk_status = STAT_RANGE;
    end else if (op_q == OP_PUSH && !push_ok) begin
      lk_status = STAT_FULL;
    end else if (op_q == OP_POP && !pop_ok) begin
      lk_status = STAT_EMPTY;
    end else begin
      lk_status = STAT_OK;
    end
  end

  // sequencer: next state and memory controls
  always_comb begin
    state_next  = state;
    in_ready    = 1'b0;
    finish      = 1'b0;
    meta_re     = 1'b0;
    meta_raddr  = MIW'(track);
    meta_we     = 1'b0;
    meta_waddr  = idx_q;
    meta_wdata  = {rp_new, wp_new, cnt_new};
    store_we    = 1'b0;
    store_re    = 1'b0;
    store_waddr = base + AW'(wp);
    store_raddr = base + AW'(rp);
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        meta_re  = in_valid;
        if (in_valid) begin
          state_next = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        meta_we    = push_ok || pop_ok;
        store_we   = push_ok;
        store_re   = pop_ok;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (!out_valid || out_ready) begin
          finish     = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // request capture and lookup result
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q    <= operation;
      trk_q   <= track;
      data_q  <= push_data[DATA_WIDTH-1:0];
      hit_vld <= (9'(track) < 9'(TRACKS)) ? meta_vld[MIW'(track)] : 1'b0;
    end
    if (state == S_LOOKUP) begin
      res_status <= lk_status;
      res_pop    <= pop_ok;
    end
  end

  // descriptor valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      meta_vld <= '0;
    end else if (meta_we) begin
      meta_vld[idx_q] <= 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      status   <= res_status;
      pop_data <= res_pop ? 64'(store_rdata) : 64'd0;
    end
  end

`ifndef ASSERT_OFF
  a_accept_to_lookup: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == S_LOOKUP)
    else $error("accepted item did not enter lookup");

  a_store_one_access: assert property (@(posedge clk) disable iff (rst)
    !(store_we && store_re))
    else $error("entry store read and written for one item");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    meta_we |-> cnt_new <= CW'(DEPTH))
    else $error("fill count beyond store depth");

  a_result_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_FINISH)
    else $error("result presented outside finishing state");

  a_fail_zero_data: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != STAT_OK) |-> pop_data == 64'd0)
    else $error("failed access returned data");
`endif

endmodule

/* hw/rtl/mtrq_ram.sv */
module mtrq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* tb/tb.sv */
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mtrq_pkg::*;

  localparam int NUM_TRACKS     = 16;
  localparam int MAX_DEPTH      = 64;
  localparam int DRAIN_CYCLES   = 8;
  localparam int WATCHDOG_LIMIT = 4000;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] word;
  } result_t;

  // block ports, all inputs known from time zero
  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  logic        operation = OP_PUSH;
  logic [3:0]  track     = '0;
  logic [63:0] push_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  status;
  logic [63:0] pop_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = CFG_TRACKS;
  logic [6:0]  cfg_data  = '0;

  multi_track_ring_queue_unit #(
    .TRACKS     (NUM_TRACKS),
    .DEPTH      (MAX_DEPTH),
    .DATA_WIDTH (64)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .operation (operation),
    .track     (track),
    .push_data (push_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .pop_data  (pop_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // predicted queue state
  logic [63:0] store_model   [NUM_TRACKS][MAX_DEPTH];
  bit          written_model [NUM_TRACKS][MAX_DEPTH];
  int          rd_ptr [NUM_TRACKS];
  int          wr_ptr [NUM_TRACKS];
  int          fill   [NUM_TRACKS];
  logic [4:0]  tracks_reg = TRACKS_RESET;
  logic [6:0]  depth_reg  = DEPTH_RESET;

  result_t awaited[$];
  int      failures;
  int      results_seen;
  int      items_sent;
  int      shapes_seen;
  int      stat_hits [4];
  int      idle_pct;
  int      stall_pct;
  int      quiet_cycles;

  function automatic int live_tracks();
    return (tracks_reg > NUM_TRACKS) ? NUM_TRACKS : int'(tracks_reg);
  endfunction

  function automatic int live_depth();
    return (depth_reg > MAX_DEPTH) ? MAX_DEPTH : int'(depth_reg);
  endfunction

  // pointer advance: wraps at the configured depth, and at the store depth
  function automatic int step_ptr(int p);
    int nxt;
    nxt = p + 1;
    if (nxt >= live_depth() || nxt >= MAX_DEPTH) nxt = 0;
    return nxt;
  endfunction

  // applies one access to the predicted state and returns its result
  function automatic result_t queue_access(logic op, logic [3:0] trk, logic [63:0] data);
    result_t r;
    r.status = STAT_OK;
    r.word   = '0;
    if (trk >= live_tracks()) begin
      r.status = STAT_RANGE;
    end else if (op == OP_PUSH) begin
      if (fill[trk] >= live_depth()) begin
        r.status = STAT_FULL;
      end else begin
        store_model[trk][wr_ptr[trk]]   = data;
        written_model[trk][wr_ptr[trk]] = 1'b1;
        wr_ptr[trk] = step_ptr(wr_ptr[trk]);
        fill[trk]++;
      end
    end else begin
      if (fill[trk] == 0) begin
        r.status = STAT_EMPTY;
      end else begin
        r.word = store_model[trk][rd_ptr[trk]];
        rd_ptr[trk] = step_ptr(rd_ptr[trk]);
        fill[trk]--;
      end
    end
    return r;
  endfunction

  // a pop must never land on a store entry that was never written
  function automatic bit pop_is_safe(int trk);
    return trk >= live_tracks() || fill[trk] == 0 || written_model[trk][rd_ptr[trk]];
  endfunction

  // one item on the request channel, with random gaps before it
  task automatic send_item(logic op, logic [3:0] trk, logic [63:0] data);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    operation <= op;
    track     <= trk;
    push_data <= data;
    do @(posedge clk); while (!in_ready);
    awaited.push_back(queue_access(op, trk, data));
    items_sent++;
  endtask

  // stop sending, let every result drain, then allow the pipeline to settle
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (awaited.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_config(logic idx, logic [6:0] val);
    wait_idle();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_TRACKS) tracks_reg = val[4:0];
    else depth_reg = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_queue_shape(int ntracks, int ndepth);
    write_config(CFG_TRACKS, 7'(ntracks));
    write_config(CFG_DEPTH, 7'(ndepth));
    shapes_seen++;
  endtask

  // reset shape: extreme data words, first and last track, pop from empty
  task automatic test_push_pop_basics();
    send_item(OP_PUSH, 4'd0, 64'hFFFF_FFFF_FFFF_FFFF);
    send_item(OP_PUSH, 4'd15, 64'h0);
    send_item(OP_POP, 4'd0, 64'h0);
    send_item(OP_POP, 4'd15, 64'hFFFF_FFFF_FFFF_FFFF);
    send_item(OP_POP, 4'd0, 64'h0);
  endtask

  // zero tracks rejects everything, oversize count saturates, one track
  task automatic test_track_limit();
    write_config(CFG_TRACKS, 7'd0);
    send_item(OP_PUSH, 4'd0, 64'hAAAA_AAAA_AAAA_AAAA);
    send_item(OP_POP, 4'd0, 64'h0);
    write_config(CFG_TRACKS, 7'd31);
    send_item(OP_PUSH, 4'd15, 64'h5555_5555_5555_5555);
    send_item(OP_POP, 4'd15, 64'h0);
    write_config(CFG_TRACKS, 7'd1);
    send_item(OP_PUSH, 4'd1, 64'h1234_5678_9ABC_DEF0);
    send_item(OP_POP, 4'd0, 64'h0);
    write_config(CFG_TRACKS, 7'd16);
    shapes_seen += 3;
  endtask

  // depth of one fills at once; oversize depth saturates
  task automatic test_depth_limit();
    write_config(CFG_DEPTH, 7'd1);
    send_item(OP_PUSH, 4'd2, 64'hAAAA_AAAA_AAAA_AAAA);
    send_item(OP_PUSH, 4'd2, 64'h5555_5555_5555_5555);
    send_item(OP_POP, 4'd2, 64'h0);
    send_item(OP_POP, 4'd2, 64'h0);
    write_config(CFG_DEPTH, 7'd127);
    send_item(OP_PUSH, 4'd2, {$urandom, $urandom});
    send_item(OP_POP, 4'd2, 64'h0);
    shapes_seen += 2;
  endtask

  // shrinking the depth while words are held, then depth zero draining
  task automatic test_depth_shrink();
    write_config(CFG_DEPTH, 7'd64);
    for (int i = 0; i < 4; i++) send_item(OP_PUSH, 4'd6, {$urandom, $urandom});
    send_item(OP_POP, 4'd6, 64'h0);
    send_item(OP_PUSH, 4'd7, {$urandom, $urandom});
    send_item(OP_PUSH, 4'd7, {$urandom, $urandom});
    // three held on track 6, read pointer wraps past the new depth
    write_config(CFG_DEPTH, 7'd3);
    send_item(OP_PUSH, 4'd6, 64'hFFFF_FFFF_FFFF_FFFF);
    for (int i = 0; i < 3; i++) send_item(OP_POP, 4'd6, 64'h0);
    // depth zero: pushes fail, pops keep reading entry zero
    write_config(CFG_DEPTH, 7'd0);
    send_item(OP_PUSH, 4'd7, 64'hFFFF_FFFF_FFFF_FFFF);
    for (int i = 0; i < 3; i++) send_item(OP_POP, 4'd7, 64'h0);
    shapes_seen += 3;
  endtask

  // bursts that lean to push then to pop, so tracks reach full and empty
  task automatic test_random_traffic(int ntracks, int ndepth, int count, int idle, int stall);
    int          bias;
    int          trk;
    int          lt;
    logic        op;
    logic [63:0] data;
    set_queue_shape(ntracks, ndepth);
    idle_pct  = idle;
    stall_pct = stall;
    bias = 80;
    for (int i = 0; i < count; i++) begin
      if (i % 48 == 47) bias = 100 - bias;
      lt = live_tracks();
      if (lt > 0 && $urandom_range(9) != 0) trk = $urandom_range(lt - 1);
      else trk = $urandom_range(NUM_TRACKS - 1);
      op = ($urandom_range(99) < bias) ? OP_PUSH : OP_POP;
      if (op == OP_POP && !pop_is_safe(trk)) op = OP_PUSH;
      case ($urandom_range(15))
        0: data = '0;
        1: data = '1;
        default: data = {$urandom, $urandom};
      endcase
      send_item(op, 4'(trk), data);
    end
    idle_pct  = 0;
    stall_pct = 0;
  endtask

  // result channel back-pressure
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // compare each result with the oldest predicted one
  always @(posedge clk) begin : check_results
    result_t exp_r;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (awaited.size() == 0) begin
        $error("unexpected result: status %0d, pop_data %h", status, pop_data);
        failures++;
      end else begin
        exp_r = awaited.pop_front();
        stat_hits[exp_r.status]++;
        if (status !== exp_r.status) begin
          $error("status: expected %0d, got %0d", exp_r.status, status);
          failures++;
        end
        if (pop_data !== exp_r.word) begin
          $error("pop_data: expected %h, got %h", exp_r.word, pop_data);
          failures++;
        end
      end
    end
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_push_pop_basics();
    test_track_limit();
    test_depth_limit();
    test_depth_shrink();

    test_random_traffic(16, 64, 150, 0, 0);
    test_random_traffic(16, 4, 150, 59, 0);
    test_random_traffic(5, 2, 150, 0, 59);
    test_random_traffic(31, 127, 100, 7, 7);
    test_random_traffic(16, 1, 120, 0, 0);
    test_random_traffic(8, 0, 80, 59, 0);
    test_random_traffic(0, 64, 40, 7, 7);
    test_random_traffic(2, 33, 200, 0, 59);

    wait_idle();
    $display("Covered %0d accesses across %0d queue shapes, %0d results checked",
             items_sent, shapes_seen, results_seen);
    $display("Statuses seen: ok %0d, out of range %0d, full %0d, empty %0d",
             stat_hits[STAT_OK], stat_hits[STAT_RANGE], stat_hits[STAT_FULL],
             stat_hits[STAT_EMPTY]);
    if (failures == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
